/* design/cdp_pkg.sv */
// ----------------------------------------------------------------------------
// cdp_pkg: shared types and constants for the caption data packet parser
// Transaction payloads, queue entry format, record kinds and status codes.
// ----------------------------------------------------------------------------
package cdp_pkg;

  // Record kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_TIMECODE = 3'd1;
  localparam logic [2:0] KIND_TRIPLET  = 3'd2;
  localparam logic [2:0] KIND_SERVICE  = 3'd3;
  localparam logic [2:0] KIND_FOOTER   = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  // End status codes
  localparam logic [1:0] STAT_GOOD      = 2'd0;
  localparam logic [1:0] STAT_CSUM_BAD  = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;

  // Section ids
  localparam logic [7:0] ID_TIMECODE = 8'h71;
  localparam logic [7:0] ID_TRIPLET  = 8'h72;
  localparam logic [7:0] ID_SERVICE  = 8'h73;
  localparam logic [7:0] ID_FOOTER   = 8'h74;

  // Queue depth between parser and formatter
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cdp_in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [4:0]  entry_index;
    logic [55:0] record_bytes;
    logic [3:0]  frame_rate_code;
    logic [6:0]  flag_bits;
    logic [15:0] sequence_count;
    logic        triplet_valid;
    logic [1:0]  cc_type;
    logic [15:0] cc_pair;
    logic [4:0]  service_number;
    logic [5:0]  service_code;
    logic [1:0]  end_status;
  } cdp_out_t;

  // One parsed event: an optional record and an optional end status
  typedef struct packed {
    logic        has_rec;
    logic        has_end;
    logic [2:0]  kind;
    logic [4:0]  entry_index;
    logic [55:0] record_bytes;
    logic [1:0]  end_status;
  } cdp_evt_t;

endpackage

/* design/cdp_front.sv */
// ----------------------------------------------------------------------------
// cdp_front: packet byte parser
// Tracks section order, collects record bytes, keeps the checksum and the
// minimum length demand, and pushes one event per byte that completes one.
// ----------------------------------------------------------------------------
module cdp_front #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdp_pkg::cdp_in_t   in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output cdp_pkg::cdp_evt_t  push_data
);
  import cdp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

  typedef enum logic [11:0] {
    PH_HDR  = 12'b0000_0000_0001,
    PH_ID0  = 12'b0000_0000_0010,
    PH_TC   = 12'b0000_0000_0100,
    PH_ID1  = 12'b0000_0000_1000,
    PH_CCN  = 12'b0000_0001_0000,
    PH_CCE  = 12'b0000_0010_0000,
    PH_ID2  = 12'b0000_0100_0000,
    PH_SVN  = 12'b0000_1000_0000,
    PH_SVE  = 12'b0001_0000_0000,
    PH_ID3  = 12'b0010_0000_0000,
    PH_FTR  = 12'b0100_0000_0000,
    PH_DONE = 12'b1000_0000_0000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       bir_r, bir_nxt;
  logic [55:0]      shift_r, shift_nxt;
  logic [4:0]       ctr_r, ctr_nxt;
  logic [4:0]       tot_r, tot_nxt;
  logic [7:0]       need_r, need_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic [7:0]       b;
  logic [7:0]       need_dec;
  logic [55:0]      col_shift;
  logic [2:0]       col_bir;
  logic [4:0]       ctr_inc;
  logic [4:0]       cc_tot;
  logic [4:0]       sv_tot;
  logic [7:0]       cc_need;
  logic [7:0]       sv_need;
  logic [7:0]       lowest;
  phase_t           id_tgt;
  logic [7:0]       id_need;
  logic [CNT_W-1:0] cnt_inc;
  logic             pkt_end;
  cdp_evt_t         ev;

  // Next section allowed by the order rule; anything else stops parsing
  function automatic phase_t id_lookup(input logic [7:0] id, input logic [7:0] low);
    phase_t p;
    if (id == ID_TIMECODE && low <= ID_TIMECODE)     p = PH_TC;
    else if (id == ID_TRIPLET && low <= ID_TRIPLET)  p = PH_CCN;
    else if (id == ID_SERVICE && low <= ID_SERVICE)  p = PH_SVN;
    else if (id == ID_FOOTER && low <= ID_FOOTER)    p = PH_FTR;
    else                                             p = PH_DONE;
    return p;
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  assign need_dec  = (need_r != 8'd0) ? need_r - 8'd1 : need_r;
  assign col_shift = {shift_r[47:0], b};
  assign col_bir   = bir_r + 3'd1;
  assign ctr_inc   = ctr_r + 5'd1;
  assign cc_tot    = b[4:0];
  assign sv_tot    = {1'b0, b[3:0]};
  assign cc_need   = {3'b000, cc_tot} + {2'b00, cc_tot, 1'b0};
  assign sv_need   = {sv_tot, 3'b000} - {3'b000, sv_tot};
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign pkt_end   = in_data.last_byte || (cnt_inc == CNT_W'(MAX_PACKET_BYTES));

  always_comb begin
    unique case (phase_r)
      PH_ID1:  lowest = ID_TRIPLET;
      PH_ID2:  lowest = ID_SERVICE;
      PH_ID3:  lowest = ID_FOOTER;
      default: lowest = ID_TIMECODE;
    endcase
    id_tgt = id_lookup(b, lowest);
    unique case (id_tgt)
      PH_TC:   id_need = 8'd5;
      PH_CCN:  id_need = 8'd2;
      PH_SVN:  id_need = 8'd3;
      PH_FTR:  id_need = 8'd3;
      default: id_need = need_dec;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    bir_nxt   = bir_r;
    shift_nxt = shift_r;
    ctr_nxt   = ctr_r;
    tot_nxt   = tot_r;
    need_nxt  = need_dec;
    sum_nxt   = sum_r + b;
    cnt_nxt   = cnt_inc;
    ev        = '0;

    unique case (phase_r)
      PH_HDR: begin
        shift_nxt = col_shift;
        bir_nxt   = col_bir;
        if (col_bir == 3'd7) begin
          ev.has_rec      = 1'b1;
          ev.kind         = KIND_HEADER;
          ev.record_bytes = col_shift;
          phase_nxt       = PH_ID0;
          need_nxt        = 8'd1;
          bir_nxt         = 3'd0;
          shift_nxt       = '0;
        end
      end
      PH_ID0, PH_ID1, PH_ID2, PH_ID3: begin
        bir_nxt   = 3'd0;
        shift_nxt = '0;
        phase_nxt = id_tgt;
        need_nxt  = id_need;
      end
      PH_TC: begin
        shift_nxt = col_shift;
        bir_nxt   = col_bir;
        if (col_bir == 3'd4) begin
          ev.has_rec      = 1'b1;
          ev.kind         = KIND_TIMECODE;
          ev.record_bytes = col_shift;
          phase_nxt       = PH_ID1;
        end
      end
      PH_CCN: begin
        tot_nxt   = cc_tot;
        ctr_nxt   = 5'd0;
        if (cc_need > need_dec) need_nxt = cc_need;
        phase_nxt = (cc_tot != 5'd0) ? PH_CCE : PH_ID2;
      end
      PH_CCE: begin
        shift_nxt = col_shift;
        bir_nxt   = col_bir;
        if (col_bir == 3'd3) begin
          ev.has_rec      = 1'b1;
          ev.kind         = KIND_TRIPLET;
          ev.entry_index  = ctr_r;
          ev.record_bytes = col_shift;
          bir_nxt         = 3'd0;
          shift_nxt       = '0;
          ctr_nxt         = ctr_inc;
          if (ctr_inc == tot_r) phase_nxt = PH_ID2;
        end
      end
      PH_SVN: begin
        tot_nxt   = sv_tot;
        ctr_nxt   = 5'd0;
        if (sv_need > need_dec) need_nxt = sv_need;
        phase_nxt = (sv_tot != 5'd0) ? PH_SVE : PH_ID3;
      end
      PH_SVE: begin
        shift_nxt = col_shift;
        bir_nxt   = col_bir;
        if (col_bir == 3'd7) begin
          ev.has_rec      = 1'b1;
          ev.kind         = KIND_SERVICE;
          ev.entry_index  = ctr_r;
          ev.record_bytes = col_shift;
          bir_nxt         = 3'd0;
          shift_nxt       = '0;
          ctr_nxt         = ctr_inc;
          if (ctr_inc == tot_r) phase_nxt = PH_ID3;
        end
      end
      PH_FTR: begin
        shift_nxt = col_shift;
        bir_nxt   = col_bir;
        if (col_bir == 3'd3) begin
          ev.has_rec      = 1'b1;
          ev.kind         = KIND_FOOTER;
          ev.record_bytes = col_shift;
          phase_nxt       = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (pkt_end) begin
      ev.has_end = 1'b1;
      if (phase_nxt == PH_HDR || need_nxt != 8'd0)
        ev.end_status = STAT_TRUNCATED;
      else if (sum_nxt != 8'd0)
        ev.end_status = STAT_CSUM_BAD;
      else
        ev.end_status = STAT_GOOD;
      // back to the idle packet state
      phase_nxt = PH_HDR;
      bir_nxt   = 3'd0;
      shift_nxt = '0;
      ctr_nxt   = 5'd0;
      tot_nxt   = 5'd0;
      need_nxt  = 8'd0;
      sum_nxt   = 8'd0;
      cnt_nxt   = '0;
    end
  end

  assign push_valid = accept && (ev.has_rec || ev.has_end);
  assign push_data  = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      bir_r   <= 3'd0;
      shift_r <= '0;
      ctr_r   <= 5'd0;
      tot_r   <= 5'd0;
      need_r  <= 8'd0;
      sum_r   <= 8'd0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      bir_r   <= bir_nxt;
      shift_r <= shift_nxt;
      ctr_r   <= ctr_nxt;
      tot_r   <= tot_nxt;
      need_r  <= need_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* design/cdp_queue.sv */
// ----------------------------------------------------------------------------
// cdp_queue: event queue between parser and formatter
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cdp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cdp_pkg::cdp_evt_t  push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cdp_pkg::cdp_evt_t  pop_data
);
  import cdp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cdp_evt_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/cdp_back.sv */
// ----------------------------------------------------------------------------
// cdp_back: record formatter and output register
// Expands each queued event into its record and end status transactions
// and decodes the per-kind fields.
// ----------------------------------------------------------------------------
module cdp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cdp_pkg::cdp_evt_t  pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdp_pkg::cdp_out_t  out_data
);
  import cdp_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  cdp_out_t   out_data_r, out_data_nxt;
  logic       pend_r, pend_nxt;
  logic [1:0] pend_stat_r, pend_stat_nxt;
  logic       can_load;

  function automatic cdp_out_t fmt_record(input cdp_evt_t e);
    cdp_out_t   o;
    logic [7:0] d3;
    logic [7:0] d4;
    o  = '0;
    d3 = e.record_bytes[23:16];
    d4 = e.record_bytes[15:8];
    o.record_kind  = e.kind;
    o.record_bytes = e.record_bytes;
    unique case (e.kind)
      KIND_HEADER: begin
        o.frame_rate_code = e.record_bytes[31:28];
        o.flag_bits       = e.record_bytes[23:17];
        o.sequence_count  = e.record_bytes[15:0];
      end
      KIND_TRIPLET: begin
        o.entry_index   = e.entry_index;
        o.triplet_valid = e.record_bytes[18];
        o.cc_type       = e.record_bytes[17:16];
        o.cc_pair       = e.record_bytes[15:0];
      end
      KIND_SERVICE: begin
        o.entry_index    = e.entry_index;
        o.flag_bits      = {4'b0000, d4[6], d4[7], d3[7]};
        o.service_number = e.record_bytes[52:48];
        o.service_code   = d3[7] ? d3[5:0] : {5'b00000, d3[0]};
      end
      KIND_FOOTER: begin
        o.sequence_count = e.record_bytes[23:8];
      end
      default: begin
        o.record_bytes = e.record_bytes;
      end
    endcase
    return o;
  endfunction

  function automatic cdp_out_t fmt_end(input logic [1:0] stat);
    cdp_out_t o;
    o             = '0;
    o.record_kind = KIND_END;
    o.end_status  = stat;
    return o;
  endfunction

  assign can_load  = !out_valid_r || out_ready;
  assign pop_ready = can_load && !pend_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    pend_stat_nxt = pend_stat_r;
    if (can_load) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fmt_end(pend_stat_r);
        pend_nxt      = 1'b0;
      end else if (pop_valid) begin
        out_valid_nxt = 1'b1;
        if (pop_data.has_rec) begin
          out_data_nxt  = fmt_record(pop_data);
          pend_nxt      = pop_data.has_end;
          pend_stat_nxt = pop_data.end_status;
        end else begin
          out_data_nxt = fmt_end(pop_data.end_status);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    pend_stat_r <= pend_stat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/caption_data_packet_parser.sv */
// ----------------------------------------------------------------------------
// caption_data_packet_parser: caption distribution packet parser, top level
// Byte-serial packet parser feeding a record formatter through a queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data): one packet byte per
//   transaction, last_byte set on the final byte. A packet is closed early
//   at its MAX_PACKET_BYTES-th byte regardless of last_byte.
//   Output channel (out_valid/out_ready/out_data): header, timecode,
//   caption triplet, service entry and footer records as each completes,
//   then one end status record per packet (good, checksum bad, truncated).
//   Records of a truncated packet are still sent; the end status tells the
//   consumer to drop them.
// Throughput and order:
//   One byte accepted per cycle while the queue has room. Each record
//   goes parser -> queue -> output reg after its last byte is accepted.
//   A byte that completes a record and the packet makes two output
//   transactions, which the formatter sends record first, then end status.
// Reset (rst_n low, synchronous): parser returns to expecting a header,
//   queue empties, output valid drops.
// Stall: when out_ready is low the output register holds, the 4-entry
//   queue fills, and in_ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module caption_data_packet_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdp_pkg::cdp_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdp_pkg::cdp_out_t  out_data
);
  import cdp_pkg::*;

  // parser -> queue
  logic     push_valid;
  logic     push_ready;
  cdp_evt_t push_data;

  // queue -> formatter
  logic     pop_valid;
  logic     pop_ready;
  cdp_evt_t pop_data;

  // Front: section order, byte collection, checksum and length demands
  cdp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue decouples the parser from output stalls
  cdp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: field decode and registered output
  cdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for caption_data_packet_parser
// Streams caption packet bytes into the parser, predicts every header,
// section and end status record in a cycle-free software model, and checks
// each output transaction field by field. Random idle and stall phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cdp_pkg::*;

  localparam int MAX_PKT       = 255;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int DRAIN_CYCLES  = 16;     // output reg sits behind parser and queue
  localparam int PHASE_BYTES   = 325;    // ~1300 random bytes over 4 phases

  // Parser position inside a packet
  typedef enum logic [11:0] {
    ST_HEADER      = 12'b0000_0000_0001,
    ST_ID_TIMECODE = 12'b0000_0000_0010,
    ST_TIMECODE    = 12'b0000_0000_0100,
    ST_ID_TRIPLET  = 12'b0000_0000_1000,
    ST_CC_COUNT    = 12'b0000_0001_0000,
    ST_CC_ENTRY    = 12'b0000_0010_0000,
    ST_ID_SERVICE  = 12'b0000_0100_0000,
    ST_SVC_COUNT   = 12'b0000_1000_0000,
    ST_SVC_ENTRY   = 12'b0001_0000_0000,
    ST_ID_FOOTER   = 12'b0010_0000_0000,
    ST_FOOTER      = 12'b0100_0000_0000,
    ST_DONE        = 12'b1000_0000_0000
  } sect_state_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  cdp_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cdp_out_t  out_data;

  // Stimulus and expectation stores
  cdp_in_t     byte_queue[$];        // packet bytes waiting for the driver
  cdp_out_t    pending_records[$];   // records predicted, not yet seen
  logic [7:0]  pkt_buf[$];           // packet under construction
  int          id_pos[$];            // where the section ids sit in pkt_buf

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int phase_bytes = 0;
  int mismatches = 0;
  int records_seen = 0;
  int cycle_cnt = 0;

  // Parser model state
  sect_state_t sect_state = ST_HEADER;
  logic [2:0]  rec_fill = '0;      // bytes collected in the open record
  logic [55:0] rec_acc = '0;       // collected record bytes, newest lowest
  logic [4:0]  entry_num = '0;
  logic [4:0]  entry_count = '0;
  int          bytes_owed = 0;     // bytes the open length demand still needs
  logic [7:0]  byte_sum = '0;
  int          pkt_len = 0;

  caption_data_packet_parser #(.MAX_PACKET_BYTES(MAX_PKT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic clear_parser();
    sect_state = ST_HEADER;
    rec_fill = '0;
    rec_acc = '0;
    entry_num = '0;
    entry_count = '0;
    bytes_owed = 0;
    byte_sum = '0;
    pkt_len = 0;
  endtask

  task automatic shift_in(input logic [7:0] b, input logic [2:0] len, output bit full);
    rec_acc = {rec_acc[47:0], b};
    rec_fill = rec_fill + 3'd1;
    full = (rec_fill == len);
  endtask

  // Sections only go forward: an id below the lowest allowed one, or an
  // unknown byte, ends parsing and the rest of the packet is just summed.
  task automatic open_section(input logic [7:0] id, input logic [7:0] lowest);
    rec_fill = '0;
    rec_acc = '0;
    if (id == ID_TIMECODE && lowest <= ID_TIMECODE) begin
      sect_state = ST_TIMECODE;
      bytes_owed = 5;
    end else if (id == ID_TRIPLET && lowest <= ID_TRIPLET) begin
      sect_state = ST_CC_COUNT;
      bytes_owed = 2;
    end else if (id == ID_SERVICE && lowest <= ID_SERVICE) begin
      sect_state = ST_SVC_COUNT;
      bytes_owed = 3;
    end else if (id == ID_FOOTER && lowest <= ID_FOOTER) begin
      sect_state = ST_FOOTER;
      bytes_owed = 3;
    end else begin
      sect_state = ST_DONE;
    end
  endtask

  task automatic expect_records_for_byte(input cdp_in_t it);
    cdp_out_t   rec;
    logic [7:0] b;
    logic [7:0] d3;
    logic [7:0] d4;
    bit         full;
    b = it.data_byte;
    byte_sum = byte_sum + b;
    pkt_len++;
    if (bytes_owed > 0) bytes_owed--;
    full = 1'b0;
    rec = '0;
    case (sect_state)
      ST_HEADER: begin
        shift_in(b, 3'd7, full);
        if (full) begin
          rec.record_kind = KIND_HEADER;
          rec.record_bytes = rec_acc;
          rec.frame_rate_code = rec_acc[31:28];
          rec.flag_bits = rec_acc[23:17];
          rec.sequence_count = rec_acc[15:0];
          pending_records.push_back(rec);
          sect_state = ST_ID_TIMECODE;
          bytes_owed = 1;
          rec_fill = '0;
          rec_acc = '0;
        end
      end
      ST_ID_TIMECODE: open_section(b, ID_TIMECODE);
      ST_TIMECODE: begin
        shift_in(b, 3'd4, full);
        if (full) begin
          rec.record_kind = KIND_TIMECODE;
          rec.record_bytes = rec_acc;
          pending_records.push_back(rec);
          sect_state = ST_ID_TRIPLET;
        end
      end
      ST_ID_TRIPLET: open_section(b, ID_TRIPLET);
      ST_CC_COUNT: begin
        entry_count = b[4:0];
        entry_num = '0;
        if (3 * entry_count > bytes_owed) bytes_owed = 3 * entry_count;
        sect_state = (entry_count != 0) ? ST_CC_ENTRY : ST_ID_SERVICE;
      end
      ST_CC_ENTRY: begin
        shift_in(b, 3'd3, full);
        if (full) begin
          rec.record_kind = KIND_TRIPLET;
          rec.entry_index = entry_num;
          rec.record_bytes = rec_acc;
          rec.triplet_valid = rec_acc[18];
          rec.cc_type = rec_acc[17:16];
          rec.cc_pair = rec_acc[15:0];
          pending_records.push_back(rec);
          rec_fill = '0;
          rec_acc = '0;
          entry_num = entry_num + 5'd1;
          if (entry_num == entry_count) sect_state = ST_ID_SERVICE;
        end
      end
      ST_ID_SERVICE: open_section(b, ID_SERVICE);
      ST_SVC_COUNT: begin
        entry_count = {1'b0, b[3:0]};
        entry_num = '0;
        if (7 * entry_count > bytes_owed) bytes_owed = 7 * entry_count;
        sect_state = (entry_count != 0) ? ST_SVC_ENTRY : ST_ID_FOOTER;
      end
      ST_SVC_ENTRY: begin
        shift_in(b, 3'd7, full);
        if (full) begin
          d3 = rec_acc[23:16];
          d4 = rec_acc[15:8];
          rec.record_kind = KIND_SERVICE;
          rec.entry_index = entry_num;
          rec.record_bytes = rec_acc;
          rec.flag_bits = {4'b0, d4[6], d4[7], d3[7]};
          rec.service_number = rec_acc[52:48];
          rec.service_code = d3[7] ? d3[5:0] : {5'b0, d3[0]};
          pending_records.push_back(rec);
          rec_fill = '0;
          rec_acc = '0;
          entry_num = entry_num + 5'd1;
          if (entry_num == entry_count) sect_state = ST_ID_FOOTER;
        end
      end
      ST_ID_FOOTER: open_section(b, ID_FOOTER);
      ST_FOOTER: begin
        shift_in(b, 3'd3, full);
        if (full) begin
          rec.record_kind = KIND_FOOTER;
          rec.record_bytes = rec_acc;
          rec.sequence_count = rec_acc[23:8];
          pending_records.push_back(rec);
          sect_state = ST_DONE;
        end
      end
      default: sect_state = ST_DONE;
    endcase

    // Packet close: explicit last byte or the size cap
    if (it.last_byte || pkt_len >= MAX_PKT) begin
      rec = '0;
      rec.record_kind = KIND_END;
      if (sect_state == ST_HEADER || bytes_owed != 0) rec.end_status = STAT_TRUNCATED;
      else if (byte_sum != 0) rec.end_status = STAT_CSUM_BAD;
      else rec.end_status = STAT_GOOD;
      pending_records.push_back(rec);
      clear_parser();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [55:0] want,
                             input logic [55:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: record %0d %s: expected 0x%0h, got 0x%0h",
                 records_seen, name, want, got);
    end
  endtask

  task automatic check_record(input cdp_out_t got);
    cdp_out_t want;
    if (pending_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: record %0d unexpected: kind %0d bytes 0x%0h",
                 records_seen, got.record_kind, got.record_bytes);
    end else begin
      want = pending_records.pop_front();
      check_field("record_kind", 56'(want.record_kind), 56'(got.record_kind));
      check_field("entry_index", 56'(want.entry_index), 56'(got.entry_index));
      check_field("record_bytes", want.record_bytes, got.record_bytes);
      check_field("frame_rate_code", 56'(want.frame_rate_code),
                  56'(got.frame_rate_code));
      check_field("flag_bits", 56'(want.flag_bits), 56'(got.flag_bits));
      check_field("sequence_count", 56'(want.sequence_count),
                  56'(got.sequence_count));
      check_field("triplet_valid", 56'(want.triplet_valid), 56'(got.triplet_valid));
      check_field("cc_type", 56'(want.cc_type), 56'(got.cc_type));
      check_field("cc_pair", 56'(want.cc_pair), 56'(got.cc_pair));
      check_field("service_number", 56'(want.service_number),
                  56'(got.service_number));
      check_field("service_code", 56'(want.service_code), 56'(got.service_code));
      check_field("end_status", 56'(want.end_status), 56'(got.end_status));
    end
    records_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Packet construction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_byte(input logic [7:0] b);
    pkt_buf.push_back(b);
  endtask

  // Rewrite the byte at pos so the packet sums to skew (0 = good checksum)
  task automatic seal_checksum(input int pos, input logic [7:0] skew);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < pkt_buf.size(); i++)
      if (i != pos) s = s + pkt_buf[i];
    pkt_buf[pos] = skew - s;
  endtask

  // Header plus each section at random, in legal order. Counts stay small
  // most of the time; now and then the largest count a section allows.
  // csum_pos is the footer checksum byte, or -1 without a footer.
  task automatic build_wellformed(output int csum_pos);
    logic [7:0] n;
    csum_pos = -1;
    pkt_buf.delete();
    id_pos.delete();
    repeat (7) add_byte(rand_byte());
    if ($urandom_range(0, 1) == 1) begin
      id_pos.push_back(pkt_buf.size());
      add_byte(ID_TIMECODE);
      repeat (4) add_byte(rand_byte());
    end
    if ($urandom_range(0, 3) != 0) begin
      id_pos.push_back(pkt_buf.size());
      add_byte(ID_TRIPLET);
      n = ($urandom_range(0, 9) == 0) ? 8'd31 : 8'($urandom_range(0, 3));
      add_byte((rand_byte() & 8'he0) | n);
      repeat (3 * n) add_byte(rand_byte());
    end
    if ($urandom_range(0, 1) == 1) begin
      id_pos.push_back(pkt_buf.size());
      add_byte(ID_SERVICE);
      n = ($urandom_range(0, 9) == 0) ? 8'd15 : 8'($urandom_range(0, 2));
      add_byte((rand_byte() & 8'hf0) | n);
      repeat (7 * n) add_byte(rand_byte());
    end
    if ($urandom_range(0, 3) != 0) begin
      id_pos.push_back(pkt_buf.size());
      add_byte(ID_FOOTER);
      add_byte(rand_byte());
      add_byte(rand_byte());
      csum_pos = pkt_buf.size();
      add_byte(8'h00);
    end
  endtask

  // Runs to or past the size cap so the parser closes the packet at the cap;
  // whatever spills over becomes a short packet of its own.
  task automatic build_oversized();
    int csum_pos;
    int target;
    build_wellformed(csum_pos);
    target = $urandom_range(MAX_PKT, MAX_PKT + 7);
    while (pkt_buf.size() < target) add_byte(rand_byte());
  endtask

  task automatic push_packet();
    cdp_in_t item;
    for (int i = 0; i < pkt_buf.size(); i++) begin
      item.data_byte = pkt_buf[i];
      item.last_byte = (i == pkt_buf.size() - 1);
      byte_queue.push_back(item);
      phase_bytes++;
    end
  endtask

  task automatic add_random_packet();
    int roll;
    int csum_pos;
    int keep;
    roll = $urandom_range(0, 99);
    if (roll >= 98) begin
      build_oversized();
    end else if (roll >= 90) begin
      // plain noise
      pkt_buf.delete();
      repeat ($urandom_range(1, 24)) add_byte(rand_byte());
    end else begin
      build_wellformed(csum_pos);
      if (csum_pos >= 0)
        seal_checksum(csum_pos, (roll >= 55 && roll < 65) ? 8'($urandom_range(1, 255)) : 8'h00);
      if (roll >= 65 && roll < 80) begin
        // cut short somewhere inside
        keep = $urandom_range(1, pkt_buf.size() - 1);
        while (pkt_buf.size() > keep) void'(pkt_buf.pop_back());
      end else if (roll >= 80) begin
        // broken section order, or trailing junk after the sections
        if (id_pos.size() != 0 && $urandom_range(0, 1) == 1)
          pkt_buf[id_pos[$urandom_range(0, id_pos.size() - 1)]] =
            ($urandom_range(0, 1) == 1) ? rand_byte() : 8'(ID_TIMECODE + $urandom_range(0, 3));
        else
          repeat ($urandom_range(1, 6)) add_byte(rand_byte());
      end
    end
    push_packet();
  endtask

  task automatic add_directed_packets();
    // Ends inside the header, all-ones bytes
    pkt_buf.delete();
    repeat (6) add_byte(8'hff);
    push_packet();
    // All-zero header, empty triplet and service sections, no footer id
    pkt_buf.delete();
    repeat (7) add_byte(8'h00);
    add_byte(ID_TRIPLET);
    add_byte(8'he0);
    add_byte(ID_SERVICE);
    add_byte(8'hf0);
    push_packet();
    // Header, one triplet, footer with a good checksum
    pkt_buf.delete();
    add_byte(8'h96); add_byte(8'h69); add_byte(8'h10); add_byte(8'h4f);
    add_byte(8'hc3); add_byte(8'h12); add_byte(8'h34);
    add_byte(ID_TRIPLET); add_byte(8'he1);
    add_byte(8'hfc); add_byte(8'h94); add_byte(8'h20);
    add_byte(ID_FOOTER); add_byte(8'h12); add_byte(8'h34); add_byte(8'h00);
    seal_checksum(pkt_buf.size() - 1, 8'h00);
    push_packet();
  endtask

  // --------------------------------------------------------------------------
  // Driver: one byte per transaction; valid holds until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted byte first, then check the output.
  // Both sides sample pre-edge values, so ordering between blocks is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expect_records_for_byte(in_data);
      if (out_valid && out_ready) check_record(out_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("ERROR: timeout after %0d cycles, %0d records outstanding",
               cycle_cnt, pending_records.size());
      $display("caption_data_packet_parser regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: four idle/stall phases, each drained before the next starts
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
        default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
      endcase
      phase_bytes = 0;
      if (ph == 0) add_directed_packets();
      if (ph == 3) begin
        // make sure the size cap closes at least one packet
        build_oversized();
        push_packet();
      end
      while (phase_bytes < PHASE_BYTES) add_random_packet();

      // Hold the sender off until every predicted record has come out
      while (byte_queue.size() != 0 || in_valid) @(posedge clk);
      while (pending_records.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_records.size() != 0)
      $display("ERROR: %0d expected records never arrived", pending_records.size());
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("caption_data_packet_parser regression: pass");
    end else begin
      $display("caption_data_packet_parser regression: fail");
    end
    $finish;
  end

endmodule

/* caption_data_packet_parser.f */
design/cdp_pkg.sv
design/cdp_front.sv
design/cdp_queue.sv
design/cdp_back.sv
design/caption_data_packet_parser.sv
tb/tb_top.sv
